// ===== src/wildcard_glob_matcher_unit_macros.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define WGM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matcher assertion failed");

// Condition implies consequence in the next cycle.
`define WGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matcher assertion failed");

// Invariant that holds in every cycle out of reset.
`define WGM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("matcher assertion failed");

`endif

// ===== src/wgm_pkg.sv =====
`default_nettype none
package wgm_pkg;

   localparam int PATTERN_DEPTH = 32;

   localparam logic [7:0] CH_ANY_ONE = 8'h3F;
   localparam logic [7:0] CH_ANY_RUN = 8'h2A;
   localparam logic [7:0] CASE_FOLD  = 8'h20;

   // Transaction operation codes
   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_SUBJECT = 2'd2,
      OP_END     = 2'd3
   } op_type;

   // Broadcast command to every cell
   typedef struct packed {
      logic       restart;
      logic       clear;
      logic       append;
      logic       subject;
      logic [7:0] char_code;
   } cmd_type;

   // Signals handed from one cell to the next
   typedef struct packed {
      logic head;   // only the first cell sees this set
      logic valid;  // previous cell holds a pattern byte
      logic carry;  // zero-width move from a star in the previous cell
      logic step;   // previous cell consumed the current subject byte
   } link_type;

endpackage
`default_nettype wire

// ===== src/wgm_cell.sv =====
`default_nettype none
module wgm_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wgm_pkg::cmd_type  cmd,
   input  wire wgm_pkg::link_type link_in,
   output wgm_pkg::link_type      link_out,
   output logic                   end_hit
);

   logic [7:0] char_ff;
   logic [7:0] char_in;
   logic       valid_ff;
   logic       valid_in;
   logic       active_ff;
   logic       active_in;

   logic       closed;
   logic       is_star;
   logic       is_any;
   logic       lit_hit;
   logic       at_end;

   // Closure through stars and byte compare
   always_comb begin
      closed   = active_ff | link_in.carry;
      is_star  = (char_ff == wgm_pkg::CH_ANY_RUN);
      is_any   = (char_ff == wgm_pkg::CH_ANY_ONE);
      lit_hit  = ((char_ff | wgm_pkg::CASE_FOLD) == (cmd.char_code | wgm_pkg::CASE_FOLD));
      at_end   = link_in.valid & ~valid_ff;
      end_hit  = closed & at_end;

      link_out.head  = 1'b0;
      link_out.valid = valid_ff;
      link_out.carry = closed & valid_ff & is_star;
      link_out.step  = closed & valid_ff & ~is_star & (is_any | lit_hit);
   end

   // Next state of the cell
   always_comb begin
      char_in   = char_ff;
      valid_in  = valid_ff;
      active_in = active_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end
      if (cmd.append && at_end) begin
         char_in  = cmd.char_code;
         valid_in = 1'b1;
      end
      if (cmd.restart) begin
         active_in = link_in.head;
      end else if (cmd.subject) begin
         active_in = (closed & valid_ff & is_star) | link_in.step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= link_in.head;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
      end
   end

   // Pattern byte: payload, no reset
   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule
`default_nettype wire

// ===== src/wildcard_glob_matcher_unit.sv =====
// A result is registered and appears on rsp_ in the cycle after its end-of-subject transaction.
// Throughput: one transaction per cycle while req_stall is low; each cell registers its position,
// star closure ripples combinationally along the cell row.
// req_stall is raised only while a result is held and rsp_stall is high.
// Reset (synchronous): pattern empty, overflow clear, position zero active, no result.
`default_nettype none
`include "wildcard_glob_matcher_unit_macros.svh"
module wildcard_glob_matcher_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   localparam int PD = wgm_pkg::PATTERN_DEPTH;

   wgm_pkg::cmd_type  cmd;
   wgm_pkg::link_type links [PD+1];
   logic [PD:0]       hit_vec;
   logic [PD:0]       end_vec;
   logic [PD-1:0]     valid_vec;
   logic              req_accept;
   logic              is_end_op;
   logic              tail_closed;

   logic tail_active_ff;
   logic tail_active_in;
   logic overflow_ff;
   logic overflow_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic matched_ff;
   logic matched_in;
   logic rsp_overflow_ff;
   logic rsp_overflow_in;

   // Handshake: output register parts the two sides
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Decode the accepted transaction into a cell command
   always_comb begin
      cmd           = '0;
      cmd.char_code = req_char_code;
      is_end_op     = 1'b0;
      if (req_accept) begin
         unique case (wgm_pkg::op_type'(req_operation))
            wgm_pkg::OP_CLEAR: begin
               cmd.clear   = 1'b1;
               cmd.restart = 1'b1;
            end
            wgm_pkg::OP_APPEND: begin
               cmd.append  = 1'b1;
               cmd.restart = 1'b1;
            end
            wgm_pkg::OP_SUBJECT: begin
               cmd.subject = 1'b1;
            end
            wgm_pkg::OP_END: begin
               cmd.restart = 1'b1;
               is_end_op   = 1'b1;
            end
            default: begin
               cmd.restart = 1'b0;
            end
         endcase
      end
   end

   // Head of the row
   assign links[0] = '{head: 1'b1, valid: 1'b1, carry: 1'b0, step: 1'b0};

   // Row of pattern cells
   for (genvar i = 0; i < PD; i++) begin : g_cell
      wgm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .end_hit  (hit_vec[i])
      );
      assign valid_vec[i] = links[i+1].valid;
      assign end_vec[i]   = links[i].valid & ~links[i+1].valid;
   end

   // Final position past the last pattern byte
   assign tail_closed  = tail_active_ff | links[PD].carry;
   assign end_vec[PD]  = links[PD].valid;
   assign hit_vec[PD]  = tail_closed & end_vec[PD];

   always_comb begin
      tail_active_in = tail_active_ff;
      if (cmd.restart) begin
         tail_active_in = 1'b0;
      end else if (cmd.subject) begin
         tail_active_in = links[PD].step;
      end
   end

   // Overflow flag
   always_comb begin
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         overflow_in = 1'b0;
      end else if (cmd.append && links[PD].valid) begin
         overflow_in = 1'b1;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      matched_in      = matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (is_end_op) begin
         rsp_valid_in    = 1'b1;
         matched_in      = |hit_vec;
         rsp_overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_active_ff <= 1'b0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tail_active_ff <= tail_active_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff      <= matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   // Checks
   `WGM_ASSERT_NEXT(a_end_gives_result, clock, reset, is_end_op, rsp_valid_ff)
   `WGM_ASSERT_ALWAYS(a_valid_prefix, clock, reset, (valid_vec & (valid_vec + 1'b1)) == '0)
   `WGM_ASSERT_ALWAYS(a_one_end, clock, reset, $onehot(end_vec))
   `WGM_ASSERT_IMP(a_overflow_full, clock, reset, overflow_ff, links[PD].valid)

endmodule
`default_nettype wire
